// ===== rtl/dct_pkg.sv =====
// Shared types and constants for the datagram connection tracker.
// No dependencies; used by dct_step and datagram_connection_tracker.
package dct_pkg;

  // Command codes carried on the input stream.
  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_LISTEN  = 3'd1,
    CMD_CONNECT = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_RX_BYTE = 3'd4
  } cmd_e;

  // Link state as reported on every result word.
  typedef enum logic [2:0] {
    ST_DISCONNECTED = 3'd0,
    ST_LISTENING    = 3'd1,
    ST_CONNECTING   = 3'd2,
    ST_CONNECT_FAIL = 3'd3,
    ST_CONNECTED    = 3'd4
  } link_state_e;

  // Role of this end of the link.
  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_CLIENT = 2'd1,
    MODE_SERVER = 2'd2
  } link_mode_e;

  // Configuration register indexes.
  localparam logic CFG_PROTOCOL_ID   = 1'b0;
  localparam logic CFG_TIMEOUT_LIMIT = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam int unsigned HEADER_BYTES  = 4;
  localparam int unsigned ELAPSED_W     = 17;

  // One input word, unpacked.
  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] tick_amount;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [7:0]  rx_data;
    logic        rx_first;
    logic        rx_last;
  } item_t;

  // Configuration registers.
  typedef struct packed {
    logic [31:0] protocol_id;
    logic [15:0] timeout_limit;
  } cfg_t;

  // One result word, unpacked.
  typedef struct packed {
    link_state_e link_state;
    link_mode_e  link_mode;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        payload_end;
    logic        connect_event;
    logic        disconnect_event;
  } result_t;

endpackage

// ===== rtl/dct_step.sv =====
// Connection state registers and the combinational step logic for one word.
// Depends on dct_pkg for the item, config and result types.
module dct_step #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_en_i,
  input  dct_pkg::item_t  item_i,
  input  dct_pkg::cfg_t   cfg_i,
  output dct_pkg::result_t result_o
);

  localparam int unsigned LIMIT = dct_pkg::HEADER_BYTES + MAX_PAYLOAD;
  localparam int unsigned POS_W = $clog2(LIMIT + 1);
  localparam int unsigned EL_W  = dct_pkg::ELAPSED_W;

  dct_pkg::link_state_e state_q, state_d;
  dct_pkg::link_mode_e  mode_q, mode_d;
  logic [31:0]          remote_ip_q, remote_ip_d;
  logic [15:0]          remote_port_q, remote_port_d;
  logic [EL_W-1:0]      elapsed_q, elapsed_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic                 pkt_ok_q, pkt_ok_d;

  logic [EL_W:0]        tick_sum;
  logic [EL_W-1:0]      tick_sat;
  logic                 timed_out;
  logic                 was_conn;
  logic                 open_now;
  logic [POS_W-1:0]     pos;
  logic [7:0]           hdr_byte;
  logic                 in_header;
  logic                 in_payload;
  logic                 accepted;
  logic                 from_peer;

  // Saturating elapsed-time add and the timeout compare.
  assign tick_sum  = (EL_W+1)'(elapsed_q) + (EL_W+1)'(item_i.tick_amount);
  assign tick_sat  = tick_sum[EL_W] ? {EL_W{1'b1}} : tick_sum[EL_W-1:0];
  assign timed_out = tick_sat > EL_W'(cfg_i.timeout_limit);
  assign was_conn  = (state_q == dct_pkg::ST_CONNECTED);

  // Packet framing: a first byte opens a packet at position zero.
  assign open_now   = item_i.rx_first | pkt_ok_q;
  assign pos        = item_i.rx_first ? '0 : pos_q;
  assign in_header  = pos < POS_W'(dct_pkg::HEADER_BYTES);
  assign in_payload = !in_header && (pos < POS_W'(LIMIT));

  // Expected header byte, most significant byte of the id first.
  always_comb begin
    case (pos[1:0])
      2'd0:    hdr_byte = cfg_i.protocol_id[31:24];
      2'd1:    hdr_byte = cfg_i.protocol_id[23:16];
      2'd2:    hdr_byte = cfg_i.protocol_id[15:8];
      default: hdr_byte = cfg_i.protocol_id[7:0];
    endcase
  end

  // A server that is not connected takes the first valid sender as its peer.
  assign accepted  = (mode_q == dct_pkg::MODE_SERVER) && !was_conn;
  assign from_peer = accepted ||
                     ((item_i.peer_ip == remote_ip_q) && (item_i.peer_port == remote_port_q));

  // Next state and result for the word in hand.
  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    remote_ip_d   = remote_ip_q;
    remote_port_d = remote_port_q;
    elapsed_d     = elapsed_q;
    pos_d         = pos_q;
    pkt_ok_d      = pkt_ok_q;
    result_o      = '0;

    unique case (item_i.command)
      dct_pkg::CMD_TICK: begin
        elapsed_d = tick_sat;
        if (timed_out && (state_q == dct_pkg::ST_CONNECTING || was_conn)) begin
          state_d                   = was_conn ? dct_pkg::ST_DISCONNECTED
                                               : dct_pkg::ST_CONNECT_FAIL;
          elapsed_d                 = '0;
          remote_ip_d               = '0;
          remote_port_d             = '0;
          result_o.disconnect_event = 1'b1;
        end
      end
      dct_pkg::CMD_LISTEN: begin
        state_d                   = dct_pkg::ST_LISTENING;
        mode_d                    = dct_pkg::MODE_SERVER;
        elapsed_d                 = '0;
        remote_ip_d               = '0;
        remote_port_d             = '0;
        result_o.disconnect_event = was_conn;
      end
      dct_pkg::CMD_CONNECT: begin
        state_d                   = dct_pkg::ST_CONNECTING;
        mode_d                    = dct_pkg::MODE_CLIENT;
        elapsed_d                 = '0;
        remote_ip_d               = item_i.peer_ip;
        remote_port_d             = item_i.peer_port;
        result_o.disconnect_event = was_conn;
      end
      dct_pkg::CMD_STOP: begin
        state_d                   = dct_pkg::ST_DISCONNECTED;
        elapsed_d                 = '0;
        remote_ip_d               = '0;
        remote_port_d             = '0;
        result_o.disconnect_event = was_conn;
      end
      dct_pkg::CMD_RX_BYTE: begin
        if (open_now) begin
          pkt_ok_d = !item_i.rx_last;
          if (in_header) begin
            if (hdr_byte != item_i.rx_data) begin
              pkt_ok_d = 1'b0;
            end
          end else if (in_payload) begin
            if (accepted) begin
              state_d                = dct_pkg::ST_CONNECTED;
              remote_ip_d            = item_i.peer_ip;
              remote_port_d          = item_i.peer_port;
              result_o.connect_event = 1'b1;
            end
            if (from_peer) begin
              if (mode_q == dct_pkg::MODE_CLIENT && state_q == dct_pkg::ST_CONNECTING) begin
                state_d                = dct_pkg::ST_CONNECTED;
                result_o.connect_event = 1'b1;
              end
              elapsed_d              = '0;
              result_o.payload_valid = 1'b1;
              result_o.payload_byte  = item_i.rx_data;
              result_o.payload_end   = item_i.rx_last || (pos == POS_W'(LIMIT - 1));
            end
          end
          pos_d = (pos < POS_W'(LIMIT)) ? pos + POS_W'(1) : pos;
        end
      end
      default: begin
        // Unassigned command codes leave everything as it is.
      end
    endcase

    result_o.link_state = state_d;
    result_o.link_mode  = mode_d;
  end

  // State update, one word per enabled cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= dct_pkg::ST_DISCONNECTED;
      mode_q        <= dct_pkg::MODE_NONE;
      remote_ip_q   <= '0;
      remote_port_q <= '0;
      elapsed_q     <= '0;
      pos_q         <= '0;
      pkt_ok_q      <= 1'b0;
    end else if (step_en_i) begin
      state_q       <= state_d;
      mode_q        <= mode_d;
      remote_ip_q   <= remote_ip_d;
      remote_port_q <= remote_port_d;
      elapsed_q     <= elapsed_d;
      pos_q         <= pos_d;
      pkt_ok_q      <= pkt_ok_d;
    end
  end

endmodule

// ===== rtl/datagram_connection_tracker.sv =====
// Top level of the datagram connection tracker: stream ports, config registers,
// input and output registers. Depends on dct_pkg and dct_step.
//
//  Channel   Direction  Carries
//  s_axis    in         one command word (tick, listen, connect, stop, rx byte)
//  m_axis    out        one result word per command word
//  cfg       in         register writes: 0 protocol_id, 1 timeout_limit
//
// A word is registered in the input register on acceptance and its result is
// registered in the output register when it advances; one word per cycle is
// sustained while m_axis does not stall. The rate is set by the single step of
// dct_step between the two registers. Reset clears the link state and both valid
// flags at once and loads the config reset values; the data registers are not
// reset. A stall on m_axis holds the result word; s_axis keeps accepting until the input register is also full.
module datagram_connection_tracker #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: tick_amount[15:0], peer_ip[47:16], peer_port[63:48], rx_data[71:64]
  input  logic [71:0] s_axis_tdata,
  // tuser: command[2:0], rx_first[3]
  input  logic [3:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: link_state[2:0], link_mode[4:3], payload_byte[12:5],
  //        connect_event[13], disconnect_event[14], zero[15]
  output logic [15:0] m_axis_tdata,
  // tuser: payload_valid[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  dct_pkg::cfg_t    cfg_q;
  dct_pkg::item_t   in_item_q;
  logic             in_valid_q;
  dct_pkg::result_t step_res;
  dct_pkg::result_t out_res_q;
  logic             out_valid_q;
  logic             advance;
  logic             in_take;

  // Move the input word into the step when the output register can take it.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.protocol_id   <= '0;
      cfg_q.timeout_limit <= dct_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dct_pkg::CFG_PROTOCOL_ID:   cfg_q.protocol_id   <= cfg_data_i;
        dct_pkg::CFG_TIMEOUT_LIMIT: cfg_q.timeout_limit <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.command     <= s_axis_tuser[2:0];
      in_item_q.tick_amount <= s_axis_tdata[15:0];
      in_item_q.peer_ip     <= s_axis_tdata[47:16];
      in_item_q.peer_port   <= s_axis_tdata[63:48];
      in_item_q.rx_data     <= s_axis_tdata[71:64];
      in_item_q.rx_first    <= s_axis_tuser[3];
      in_item_q.rx_last     <= s_axis_tlast;
    end
  end

  // Connection state and step logic.
  dct_step #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_item_q),
    .cfg_i     (cfg_q),
    .result_o  (step_res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  // Result word packing.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_res_q.disconnect_event, out_res_q.connect_event,
                          out_res_q.payload_byte, out_res_q.link_mode,
                          out_res_q.link_state};
  assign m_axis_tuser  = out_res_q.payload_valid;
  assign m_axis_tlast  = out_res_q.payload_end;

`ifndef SYNTHESIS
  // Input backs up only while a finished word waits downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without an output stall");

  // A connect event always reports the connected state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[13]) |-> (m_axis_tdata[2:0] == 3'(dct_pkg::ST_CONNECTED)))
    else $error("connect event without connected state");

  // Connect and disconnect never pulse together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[13] && m_axis_tdata[14]))
    else $error("connect and disconnect in one word");

  // Payload end and byte are only set alongside valid payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (!m_axis_tlast && m_axis_tdata[12:5] == 8'h00))
    else $error("payload fields set without payload_valid");
`endif

endmodule
